@@ design/bpd_pkg.sv @@
// Package for the bounded positional deque: command and status codes and
// the control record passed from the command decoder to the cell row.
// No dependencies.
`timescale 1ns / 1ps

package bpd_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_INSERT_AT  = 3'd4,
		CMD_ERASE_AT   = 3'd5,
		CMD_CLEAR      = 3'd6,
		CMD_READ_AT    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// ins: open a gap at the index and load the word there
	// del: close the gap at the index; take: the word at the index is returned
	typedef struct packed {
		status_t status;
		logic    ins;
		logic    del;
		logic    clr;
		logic    take;
	} ctrl_t;

endpackage

@@ design/bpd_decode.sv @@
// Command decoder: checks the request against the held count and yields
// the status, the cell operation and the index it acts on.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_decode #(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int XW = (CW > bpd_pkg::POS_W) ? CW : bpd_pkg::POS_W
) (
	input  bpd_pkg::cmd_t             command,
	input  logic [bpd_pkg::POS_W-1:0] position,
	input  logic [CW-1:0]             cnt,
	output bpd_pkg::ctrl_t            ctrl,
	output logic [XW-1:0]             idx
);
	import bpd_pkg::*;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic          full;
	logic          empty;

	assign cnt_x = XW'(cnt);
	assign pos_x = XW'(position);
	assign full  = (cnt_x == XW'(DEPTH));
	assign empty = (cnt_x == '0);

	always_comb begin
		ctrl = '{status: ST_OK, ins: 1'b0, del: 1'b0, clr: 1'b0, take: 1'b0};
		idx  = '0;
		case (command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				idx = (command == CMD_PUSH_BACK) ? cnt_x : '0;
				if (full) ctrl.status = ST_FULL;
				else ctrl.ins = 1'b1;
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				idx = (command == CMD_POP_BACK) ? cnt_x - XW'(1) : '0;
				if (empty) begin
					ctrl.status = ST_EMPTY;
				end else begin
					ctrl.del  = 1'b1;
					ctrl.take = 1'b1;
				end
			end
			CMD_INSERT_AT: begin
				idx = pos_x;
				// position checked before fullness
				if (pos_x > cnt_x) ctrl.status = ST_BADPOS;
				else if (full) ctrl.status = ST_FULL;
				else ctrl.ins = 1'b1;
			end
			CMD_ERASE_AT, CMD_READ_AT: begin
				idx = pos_x;
				if (empty) begin
					ctrl.status = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					ctrl.status = ST_BADPOS;
				end else begin
					ctrl.del  = (command == CMD_ERASE_AT);
					ctrl.take = 1'b1;
				end
			end
			CMD_CLEAR: begin
				ctrl.clr = 1'b1;
			end
			default: begin
				ctrl.status = ST_OK;
			end
		endcase
	end

endmodule

@@ design/bpd_cell_row.sv @@
// Row of word cells kept packed from the front, with the held count. Each
// cell picks hold, load or take-from-neighbour; also gives the word at the
// index and the front and back words as they will be after the update.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_cell_row #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int XW = (CW > bpd_pkg::POS_W) ? CW : bpd_pkg::POS_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  bpd_pkg::ctrl_t               ctrl,
	input  logic [XW-1:0]                idx,
	input  logic signed [DATA_WIDTH-1:0] word,
	output logic [CW-1:0]                cnt_q,
	output logic [CW-1:0]                cnt_d,
	output logic signed [DATA_WIDTH-1:0] read_word,
	output logic signed [DATA_WIDTH-1:0] front_word,
	output logic signed [DATA_WIDTH-1:0] back_word
);
	import bpd_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic signed [DATA_WIDTH-1:0] cells_q [DEPTH];
	logic signed [DATA_WIDTH-1:0] cells_d [DEPTH];
	logic [AW-1:0]                back_idx;
	logic                         back_shrinks;
	logic                         at_back;

	// per cell: hold below idx, shift by one at/above; insert loads word at idx
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_comb begin
			cells_d[i] = cells_q[i];
			if (ctrl.ins && XW'(i) == idx) begin
				cells_d[i] = word;
			end else if (ctrl.ins && XW'(i) > idx) begin
				if (i > 0) cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
			end else if (ctrl.del && XW'(i) >= idx) begin
				if (i < DEPTH - 1) cells_d[i] = cells_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end

		// contents undefined until written; never read beyond the count
		always_ff @(posedge clk) begin
			if (load) cells_q[i] <= cells_d[i];
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ctrl.clr) cnt_d = '0;
		else if (ctrl.ins) cnt_d = cnt_q + CW'(1);
		else if (ctrl.del) cnt_d = cnt_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (load) cnt_q <= cnt_d;
	end

	// reads come from the current cells, adjusted for the pending shift
	assign at_back      = (idx == XW'(cnt_q) - XW'(1));
	assign back_shrinks = ctrl.del && at_back;
	assign back_idx     = AW'(cnt_q) - AW'(1) - AW'(back_shrinks);

	always_comb begin
		read_word = '0;
		if (ctrl.take) read_word = cells_q[idx[AW-1:0]];

		front_word = cells_q[0];
		if (ctrl.ins && idx == '0) front_word = word;
		else if (ctrl.del && idx == '0) front_word = cells_q[1];

		back_word = cells_q[back_idx];
		if (ctrl.ins && idx == XW'(cnt_q)) back_word = word;

		if (cnt_d == '0) begin
			front_word = '0;
			back_word  = '0;
		end
	end

endmodule

@@ design/bounded_positional_deque.sv @@
// Top level of the bounded positional deque: input register, command
// decoder, cell row and result register with stream handshakes.
// Depends on bpd_pkg, bpd_decode and bpd_cell_row.
//
//  port group  dir  tdata fields (lsb first)                tuser
//  s_*         in   value[31:0], position[36:32]            command
//  m_*         out  read_value[31:0], front_value[63:32],   status
//                   back_value[95:64], entry_count[100:96],
//                   is_empty[101]
//
// One command per clock unless the result is stalled; a taken request waits in the
// input register, and the cell update and the result register then load together.
// The cells, the count and the result all load in the same edge, so the
// next command sees the updated list with no bubble.
// Reset clears the count and both valid flags; cell contents stay as
// they are and are never read before being written.
// A stalled result holds the input register, which then holds s_tready low.
`timescale 1ns / 1ps

module bounded_positional_deque #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [39:0]                      s_tdata,  // value, position
	input  logic [bpd_pkg::CMD_W-1:0]        s_tuser,  // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [103:0]                     m_tdata,  // read_value, front_value,
	                                                   // back_value, entry_count, is_empty
	output logic [bpd_pkg::STATUS_W-1:0]     m_tuser   // status
);
	import bpd_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic                       v_s1;
	cmd_t                       cmd_s1;
	logic signed [VALUE_W-1:0]  value_s1;
	logic [POS_W-1:0]           pos_s1;

	logic                       v_s2;
	status_t                    status_s2;
	logic [VALUE_W-1:0]         read_s2;
	logic [VALUE_W-1:0]         front_s2;
	logic [VALUE_W-1:0]         back_s2;
	logic [COUNT_W-1:0]         count_s2;
	logic                       empty_s2;

	logic                       advance;
	ctrl_t                      ctrl;
	logic [XW-1:0]              idx;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              cnt_d;
	logic signed [DATA_WIDTH-1:0] word;
	logic signed [DATA_WIDTH-1:0] read_word;
	logic signed [DATA_WIDTH-1:0] front_word;
	logic signed [DATA_WIDTH-1:0] back_word;

	assign advance  = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (advance) v_s2 <= 1'b1;
			else if (m_tready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= cmd_t'(s_tuser);
			value_s1 <= s_tdata[VALUE_W-1:0];
			pos_s1   <= s_tdata[VALUE_W+POS_W-1:VALUE_W];
		end
	end

	// low bits kept, sign-extended when cells are wider than the port
	assign word = DATA_WIDTH'(value_s1);

	bpd_decode #(.DEPTH(DEPTH)) u_decode (
		.command  (cmd_s1),
		.position (pos_s1),
		.cnt      (cnt_q),
		.ctrl     (ctrl),
		.idx      (idx)
	);

	bpd_cell_row #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_cells (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.ctrl       (ctrl),
		.idx        (idx),
		.word       (word),
		.cnt_q      (cnt_q),
		.cnt_d      (cnt_d),
		.read_word  (read_word),
		.front_word (front_word),
		.back_word  (back_word)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= ctrl.status;
			read_s2   <= VALUE_W'(read_word);
			front_s2  <= VALUE_W'(front_word);
			back_s2   <= VALUE_W'(back_word);
			count_s2  <= COUNT_W'(cnt_d);
			empty_s2  <= (cnt_d == '0);
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {2'b00, empty_s2, count_s2, back_s2, front_s2, read_s2};

	// count never runs past the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("held count above capacity");

	// a result reporting full belongs to a list that is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && status_s2 == ST_FULL) |-> (cnt_q == CW'(DEPTH)))
		else $error("full status with spare capacity");

	// an accepted insertion grows the list by exactly one
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctrl.ins) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("insertion did not grow the count");

	// a rejected command leaves the count alone
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctrl.status != ST_OK) |=> $stable(cnt_q))
		else $error("rejected command changed the count");

endmodule

@@ dv/tb.sv @@
// Testbench for bounded_positional_deque: drives random and directed command
// requests, predicts every result in a scoreboard and checks them in order.
// Depends on bpd_pkg and the RTL under design/.
`timescale 1ns / 1ps

module tb;
	import bpd_pkg::*;

	localparam int DEPTH = 16;

	typedef struct {
		status_t     status;
		logic [31:0] read_value;
		logic [31:0] front_value;
		logic [31:0] back_value;
		logic [4:0]  entry_count;
		logic        is_empty;
	} deque_result_t;

	// Shadow copy of the list: predicts each result as its request is taken
	class deque_scoreboard;
		logic [31:0]   words [DEPTH];
		int unsigned   held;
		int unsigned   accepted;
		int unsigned   errors;
		deque_result_t expected_q [$];

		function void note_request(cmd_t c, logic [31:0] v, logic [4:0] p);
			deque_result_t r;
			int unsigned   slot;
			r.status = ST_OK;
			r.read_value = '0;
			slot = 0;
			accepted++;
			case (c)
				CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
					slot = (c == CMD_PUSH_FRONT) ? 0 : (c == CMD_PUSH_BACK) ? held : p;
					// bad position wins over full for insert
					if (c == CMD_INSERT_AT && p > held)
						r.status = ST_BADPOS;
					else if (held >= DEPTH)
						r.status = ST_FULL;
					else begin
						for (int i = held; i > slot; i--)
							words[i] = words[i-1];
						words[slot] = v;
						held++;
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE_AT, CMD_READ_AT: begin
					slot = (c == CMD_POP_FRONT) ? 0 : (c == CMD_POP_BACK) ? held - 1 : p;
					if (held == 0)
						r.status = ST_EMPTY;
					else if (slot >= held)
						r.status = ST_BADPOS;
					else begin
						r.read_value = words[slot];
						if (c != CMD_READ_AT) begin
							for (int i = slot; i < held - 1; i++)
								words[i] = words[i+1];
							held--;
						end
					end
				end
				default: held = 0;
			endcase
			r.front_value = held ? words[0] : '0;
			r.back_value  = held ? words[held-1] : '0;
			r.entry_count = held[4:0];
			r.is_empty    = (held == 0);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t tb: %s", $time, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(logic [1:0] st, logic [103:0] d);
			deque_result_t r;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no request pending");
				return;
			end
			r = expected_q[0];
			expected_q.delete(0);
			compare_field("status", st, r.status);
			compare_field("read_value", d[31:0], r.read_value);
			compare_field("front_value", d[63:32], r.front_value);
			compare_field("back_value", d[95:64], r.back_value);
			compare_field("entry_count", d[100:96], r.entry_count);
			compare_field("is_empty", d[101], r.is_empty);
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // value[31:0], position[36:32], zero pad
	logic [2:0]   s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;   // read_value, front_value, back_value, entry_count, is_empty
	logic [1:0]   m_tuser;   // status

	deque_scoreboard sb = new();
	int unsigned     burst_left = 0;
	logic [15:0]     stall_pattern = 16'hffff;
	int unsigned     pattern_age = 0;

	bounded_positional_deque #(.DEPTH(DEPTH), .DATA_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: rotating stall mask, reloaded now and then; all-ones gives free runs
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			pattern_age = $urandom_range(16, 200);
			stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff
				: (16'($urandom) | 16'h0001);
		end else begin
			pattern_age--;
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
		m_tready <= stall_pattern[0];
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// one request; bursts of random length separated by random gaps
	task automatic send_request(cmd_t c, logic [31:0] v, logic [4:0] p);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, p, v};
		s_tuser  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(c, v, p);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic fill_list();
		int unsigned k;
		while (sb.held < DEPTH) begin
			k = $urandom_range(0, 2);
			if (k == 0)
				send_request(CMD_PUSH_FRONT, rand_word(), 5'($urandom));
			else if (k == 1)
				send_request(CMD_PUSH_BACK, rand_word(), 5'($urandom));
			else
				send_request(CMD_INSERT_AT, rand_word(), 5'($urandom_range(0, sb.held)));
		end
		// requests against a full list
		repeat ($urandom_range(1, 4)) begin
			k = $urandom_range(0, 4);
			case (k)
				0: send_request(CMD_PUSH_FRONT, rand_word(), 5'($urandom));
				1: send_request(CMD_PUSH_BACK, rand_word(), 5'($urandom));
				2: send_request(CMD_INSERT_AT, rand_word(), 5'($urandom_range(0, DEPTH)));
				3: send_request(CMD_INSERT_AT, rand_word(),
					5'($urandom_range(DEPTH + 1, 31)));
				default: send_request(CMD_READ_AT, rand_word(),
					5'($urandom_range(0, DEPTH)));
			endcase
		end
	endtask

	task automatic drain_list();
		int unsigned k;
		while (sb.held > 0) begin
			k = $urandom_range(0, 4);
			case (k)
				0: send_request(CMD_POP_FRONT, rand_word(), 5'($urandom));
				1: send_request(CMD_POP_BACK, rand_word(), 5'($urandom));
				2, 3: send_request(CMD_ERASE_AT, rand_word(),
					5'($urandom_range(0, sb.held - 1)));
				default: send_request(CMD_READ_AT, rand_word(),
					5'($urandom_range(0, sb.held - 1)));
			endcase
		end
		// requests against an empty list
		repeat ($urandom_range(1, 3)) begin
			k = $urandom_range(0, 4);
			case (k)
				0: send_request(CMD_POP_FRONT, rand_word(), 5'($urandom));
				1: send_request(CMD_POP_BACK, rand_word(), 5'($urandom));
				2: send_request(CMD_ERASE_AT, rand_word(), 5'($urandom));
				3: send_request(CMD_READ_AT, rand_word(), 5'($urandom));
				default: send_request(CMD_INSERT_AT, rand_word(), 5'($urandom_range(1, 31)));
			endcase
		end
	endtask

	task automatic mixed_run(int unsigned n);
		cmd_t        c;
		logic [4:0]  p;
		repeat (n) begin
			c = cmd_t'($urandom_range(0, 7));
			if (c == CMD_CLEAR && $urandom_range(0, 7) != 0)
				c = CMD_READ_AT;
			// mostly near the valid range, sometimes anywhere in the field
			if ($urandom_range(0, 3) != 0)
				p = 5'($urandom_range(0, sb.held + 1));
			else
				p = 5'($urandom);
			send_request(c, rand_word(), p);
		end
	endtask

	task automatic run_directed();
		send_request(CMD_CLEAR, 32'h0, 5'd0);
		send_request(CMD_POP_FRONT, 32'h0, 5'd0);
		send_request(CMD_POP_BACK, 32'hffff_ffff, 5'd31);
		send_request(CMD_ERASE_AT, 32'h0, 5'd0);
		send_request(CMD_READ_AT, 32'h0, 5'd0);
		send_request(CMD_INSERT_AT, 32'h1234_5678, 5'd1);
		send_request(CMD_INSERT_AT, 32'h8000_0000, 5'd0);
		send_request(CMD_PUSH_BACK, 32'h7fff_ffff, 5'd0);
		send_request(CMD_PUSH_FRONT, 32'hffff_ffff, 5'd0);
		send_request(CMD_INSERT_AT, 32'h0000_0000, 5'd3);
		send_request(CMD_INSERT_AT, 32'h0000_0001, 5'd2);
		send_request(CMD_READ_AT, 32'h0, 5'd0);
		send_request(CMD_READ_AT, 32'h0, 5'd4);
		send_request(CMD_READ_AT, 32'h0, 5'd5);
		send_request(CMD_READ_AT, 32'h0, 5'd31);
		send_request(CMD_ERASE_AT, 32'h0, 5'd16);
		send_request(CMD_ERASE_AT, 32'h0, 5'd2);
		send_request(CMD_POP_FRONT, 32'h0, 5'd0);
		send_request(CMD_POP_BACK, 32'h0, 5'd0);
		send_request(CMD_CLEAR, 32'h0, 5'd0);
		send_request(CMD_READ_AT, 32'h0, 5'd0);
	endtask

	task automatic run_random(int unsigned target);
		int unsigned start;
		int unsigned k;
		start = sb.accepted;
		while (sb.accepted - start < target) begin
			k = $urandom_range(0, 9);
			if (k < 3)
				fill_list();
			else if (k < 5)
				drain_list();
			else
				mixed_run($urandom_range(10, 50));
			if ($urandom_range(0, 11) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_PUSH_FRONT;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		hold_until_drained();
		run_random(1850);
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
